@@ src/mpce_pkg.sv @@
// Package for the memory patch code executor.
// Holds the item kind codes, cheat opcodes and the fixed EE write targets.
// Used by memory_patch_code_executor; no dependencies.
package mpce_pkg;

    typedef enum logic [1:0] {
        KIND_HOST_WR = 2'd0,
        KIND_HOST_RD = 2'd1,
        KIND_BOOT    = 2'd2,
        KIND_FRAME   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_BYTE,
        WR_HALF,
        WR_EE
    } wr_sel_t;

    localparam logic [3:0] TEST_NIBBLE = 4'hD;

    localparam logic [7:0] OP_W8      = 8'h80;
    localparam logic [7:0] OP_W16     = 8'h81;
    localparam logic [7:0] OP_BTN_W8  = 8'h88;
    localparam logic [7:0] OP_BTN_W16 = 8'h89;
    localparam logic [7:0] OP_A_W8    = 8'hA0;
    localparam logic [7:0] OP_A_W16   = 8'hA1;
    localparam logic [7:0] OP_AB_W8   = 8'hA8;
    localparam logic [7:0] OP_AB_W16  = 8'hA9;
    localparam logic [7:0] OP_BOOT_W8 = 8'hF0;
    localparam logic [7:0] OP_BOOT_W16 = 8'hF1;
    localparam logic [7:0] OP_EE      = 8'hEE;

    localparam logic [7:0] OP_EQ8      = 8'hD0;
    localparam logic [7:0] OP_EQ16     = 8'hD1;
    localparam logic [7:0] OP_NE8      = 8'hD2;
    localparam logic [7:0] OP_NE16     = 8'hD3;
    localparam logic [7:0] OP_BTN_EQ8  = 8'hD8;
    localparam logic [7:0] OP_BTN_EQ16 = 8'hD9;
    localparam logic [7:0] OP_BTN_NE16 = 8'hDA;
    localparam logic [7:0] OP_BTN_NE8  = 8'hDB;

    localparam logic [23:0] EE_ADDR0 = 24'h000318;
    localparam logic [23:0] EE_ADDR1 = 24'h00031A;
    localparam logic [15:0] EE_DATA0 = 16'h0040;
    localparam logic [15:0] EE_DATA1 = 16'h0000;

endpackage

@@ src/mpce_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read.
// Used for the byte banks of the patch code executor; no dependencies.
module mpce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/memory_patch_code_executor.sv @@
// Top level of the memory patch code executor: byte memory plus cheat code interpreter.
// Depends on mpce_pkg and mpce_ram (two byte banks, even and odd addresses).
//
// Usage: items enter on the input channel (in_valid, in_stall) carrying kind,
// address, value, cheat_start and gs_button. Each item yields exactly one
// result on the output channel (out_valid, out_stall) with read_data, wrote,
// test_passed and skipped. An item is taken when valid is high and stall low.
// The memory is split into an even and an odd bank so a halfword is one access.
// An item reads the banks in the cycle it is accepted and is resolved in the
// execute stage, where its writes are made and its result is loaded into the
// output register. A new item is taken every cycle while the input is not
// stalled; an EE code makes two halfword writes, to both banks, and holds the
// execute stage until the second write is made. A write in the same cycle as a
// read of the same entry is forwarded. Reset clears the skip flag and all valid
// state; memory contents stay undefined until written. When the receiver
// stalls, the output register holds and the input stalls once the execute
// stage is also full.
module memory_patch_code_executor
    import mpce_pkg::*;
#(
    parameter int ADDR_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [31:0] address,
    input  logic [15:0] value,
    input  logic        cheat_start,
    input  logic        gs_button,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic        wrote,
    output logic        test_passed,
    output logic        skipped
);

    localparam int IDX_BITS = ADDR_BITS - 1;
    localparam int BANK_DEPTH = 1 << IDX_BITS;
    localparam logic [IDX_BITS-1:0] EE_IDX0 = EE_ADDR0[ADDR_BITS-1:1];
    localparam logic [IDX_BITS-1:0] EE_IDX1 = EE_ADDR1[ADDR_BITS-1:1];

    logic                s1_valid_reg;
    kind_t               s1_kind_reg;
    logic [7:0]          s1_op_reg;
    logic [IDX_BITS-1:0] s1_idx_reg;
    logic                s1_bsel_reg;
    logic [15:0]         s1_value_reg;
    logic                s1_start_reg;
    logic                s1_button_reg;
    logic                phase_reg;
    logic                skip_reg;
    logic                skip_next;

    logic                fwd_e_valid_reg;
    logic                fwd_o_valid_reg;
    logic [7:0]          fwd_e_data_reg;
    logic [7:0]          fwd_o_data_reg;

    logic                out_valid_reg;
    logic [7:0]          read_data_reg;
    logic                wrote_reg;
    logic                passed_reg;
    logic                skipped_reg;

    logic                accept;
    logic                fire;
    logic                out_free;
    logic [IDX_BITS-1:0] raddr;
    logic [7:0]          q_even;
    logic [7:0]          q_odd;
    logic [7:0]          rd_even;
    logic [7:0]          rd_odd;
    logic [7:0]          rd8;
    logic [15:0]         rd16;

    logic                skip_base;
    wr_sel_t             wr_sel;
    logic                is_test;
    logic                test_ok;
    logic                skip_hit;

    logic                we_e;
    logic                we_o;
    logic [IDX_BITS-1:0] wa_e;
    logic [IDX_BITS-1:0] wa_o;
    logic [7:0]          wd_e;
    logic [7:0]          wd_o;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !fire;
    assign accept   = in_valid && !in_stall;
    assign raddr    = address[ADDR_BITS-1:1];

    mpce_ram #(
        .WIDTH(8),
        .DEPTH(BANK_DEPTH)
    ) u_bank_even (
        .clk   (clk),
        .we    (we_e),
        .waddr (wa_e),
        .wdata (wd_e),
        .re    (accept),
        .raddr (raddr),
        .rdata (q_even)
    );

    mpce_ram #(
        .WIDTH(8),
        .DEPTH(BANK_DEPTH)
    ) u_bank_odd (
        .clk   (clk),
        .we    (we_o),
        .waddr (wa_o),
        .wdata (wd_o),
        .re    (accept),
        .raddr (raddr),
        .rdata (q_odd)
    );

    assign rd_even = fwd_e_valid_reg ? fwd_e_data_reg : q_even;
    assign rd_odd  = fwd_o_valid_reg ? fwd_o_data_reg : q_odd;
    assign rd8     = s1_bsel_reg ? rd_odd : rd_even;
    assign rd16    = {rd_even, rd_odd};

    always_comb
    begin
        skip_base = s1_start_reg ? 1'b0 : skip_reg;
        skip_next = skip_base;
        wr_sel    = WR_NONE;
        is_test   = 1'b0;
        test_ok   = 1'b1;
        skip_hit  = 1'b0;
        unique case (s1_kind_reg)
            KIND_HOST_WR:
            begin
                wr_sel = WR_BYTE;
            end
            KIND_HOST_RD:
            begin
                wr_sel = WR_NONE;
            end
            KIND_BOOT:
            begin
                if (s1_op_reg == OP_BOOT_W8)
                begin
                    wr_sel = WR_BYTE;
                end
                else if (s1_op_reg == OP_BOOT_W16)
                begin
                    wr_sel = WR_HALF;
                end
            end
            KIND_FRAME:
            begin
                if (s1_op_reg[7:4] == TEST_NIBBLE)
                begin
                    is_test = 1'b1;
                    unique case (s1_op_reg)
                        OP_EQ8, OP_BTN_EQ8:   test_ok = (rd8 == s1_value_reg[7:0]);
                        OP_EQ16, OP_BTN_EQ16: test_ok = (rd16 == s1_value_reg);
                        OP_NE8, OP_BTN_NE8:   test_ok = (rd8 != s1_value_reg[7:0]);
                        OP_NE16, OP_BTN_NE16: test_ok = (rd16 != s1_value_reg);
                        default:              test_ok = 1'b1;
                    endcase
                    if (s1_op_reg[3] && (s1_op_reg[2:0] <= 3'd3) && !s1_button_reg)
                    begin
                        test_ok = 1'b0;
                    end
                    skip_next = skip_base | ~test_ok;
                end
                else if (skip_base)
                begin
                    skip_hit  = 1'b1;
                    skip_next = 1'b0;
                end
                else
                begin
                    skip_next = 1'b0;
                    unique case (s1_op_reg)
                        OP_W8, OP_A_W8:        wr_sel = WR_BYTE;
                        OP_W16, OP_A_W16:      wr_sel = WR_HALF;
                        OP_BTN_W8, OP_AB_W8:   wr_sel = s1_button_reg ? WR_BYTE : WR_NONE;
                        OP_BTN_W16, OP_AB_W16: wr_sel = s1_button_reg ? WR_HALF : WR_NONE;
                        OP_EE:                 wr_sel = WR_EE;
                        default:               wr_sel = WR_NONE;
                    endcase
                end
            end
            default:
            begin
                wr_sel = WR_NONE;
            end
        endcase
    end

    assign fire = s1_valid_reg && out_free && ((wr_sel != WR_EE) || phase_reg);

    always_comb
    begin
        we_e = 1'b0;
        we_o = 1'b0;
        wa_e = s1_idx_reg;
        wa_o = s1_idx_reg;
        wd_e = s1_value_reg[15:8];
        wd_o = s1_value_reg[7:0];
        unique case (wr_sel)
            WR_NONE:
            begin
                we_e = 1'b0;
            end
            WR_BYTE:
            begin
                wd_e = s1_value_reg[7:0];
                we_e = fire && !s1_bsel_reg;
                we_o = fire && s1_bsel_reg;
            end
            WR_HALF:
            begin
                we_e = fire;
                we_o = fire;
            end
            WR_EE:
            begin
                if (!phase_reg)
                begin
                    we_e = s1_valid_reg;
                    we_o = s1_valid_reg;
                    wa_e = EE_IDX0;
                    wa_o = EE_IDX0;
                    wd_e = EE_DATA0[15:8];
                    wd_o = EE_DATA0[7:0];
                end
                else
                begin
                    we_e = fire;
                    we_o = fire;
                    wa_e = EE_IDX1;
                    wa_o = EE_IDX1;
                    wd_e = EE_DATA1[15:8];
                    wd_o = EE_DATA1[7:0];
                end
            end
            default:
            begin
                we_e = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            phase_reg       <= 1'b0;
            skip_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            fwd_e_valid_reg <= 1'b0;
            fwd_o_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg    <= 1'b1;
                fwd_e_valid_reg <= we_e && (wa_e == raddr);
                fwd_o_valid_reg <= we_o && (wa_o == raddr);
            end
            else if (fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                phase_reg <= 1'b0;
                skip_reg  <= skip_next;
            end
            else if (s1_valid_reg && (wr_sel == WR_EE) && !phase_reg)
            begin
                phase_reg <= 1'b1;
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg    <= kind_t'(kind);
            s1_op_reg      <= address[31:24];
            s1_idx_reg     <= address[ADDR_BITS-1:1];
            s1_bsel_reg    <= address[0];
            s1_value_reg   <= value;
            s1_start_reg   <= cheat_start;
            s1_button_reg  <= gs_button;
            fwd_e_data_reg <= wd_e;
            fwd_o_data_reg <= wd_o;
        end
        if (fire)
        begin
            read_data_reg <= (s1_kind_reg == KIND_HOST_RD) ? rd8 : 8'd0;
            wrote_reg     <= (wr_sel != WR_NONE);
            passed_reg    <= is_test && test_ok;
            skipped_reg   <= skip_hit;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_data   = read_data_reg;
    assign wrote       = wrote_reg;
    assign test_passed = passed_reg;
    assign skipped     = skipped_reg;

endmodule
